>>> rtl/core/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg
// shared types and constants for the group reverse stream block
// ----------------------------------------------------------------------------
package grs_pkg;

    localparam int MAX_GROUP = 16;
    localparam int DATA_W    = 32;
    localparam int GS_W      = 5;
    localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int NUM_BANKS = 2;
    localparam int BANK_W    = 1;
    localparam int MEM_AW    = ADDR_W + BANK_W;
    localparam int CMD_DEPTH = 2;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OQ_AW     = $clog2(OUT_DEPTH);
    localparam int OQ_CW     = $clog2(OUT_DEPTH + 1);

    localparam logic [GS_W-1:0] GS_RESET = GS_W'(2);

    typedef struct packed {
        logic signed [DATA_W-1:0] item_value;
        logic                     is_final;
    } t_grs_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic                     out_final;
    } t_grs_out;

    // one finished group handed from the front to the back
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [CNT_W-1:0]  count;
        logic              reverse;
        logic              last;
    } t_grs_cmd;

    // back tells the front a bank has been fully read
    typedef struct packed {
        logic              valid;
        logic [BANK_W-1:0] bank;
    } t_grs_rel;

    function automatic logic [CNT_W-1:0] grs_eff_group(input logic [GS_W-1:0] gs);
        int g;
        g = int'(gs);
        if (g < 1) g = 1;
        if (g > MAX_GROUP) g = MAX_GROUP;
        return CNT_W'(g);
    endfunction

endpackage

>>> rtl/core/grs_ram.sv
// ----------------------------------------------------------------------------
// grs_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module grs_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/grs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// grs_cmd_fifo
// short queue of group commands between front and back
// ----------------------------------------------------------------------------
module grs_cmd_fifo import grs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_grs_cmd i_cmd,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_grs_cmd o_cmd
);

    t_grs_cmd            r_q [CMD_DEPTH];
    logic [CMD_AW-1:0]   r_wp, n_wp;
    logic [CMD_AW-1:0]   r_rp, n_rp;
    logic [CMD_CW-1:0]   r_cnt, n_cnt;
    logic                push_ok;
    logic                pop_ok;

    assign o_full  = (r_cnt == CMD_CW'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wp = (r_wp == CMD_AW'(CMD_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop_ok) begin
            n_rp = (r_rp == CMD_AW'(CMD_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/grs_front.sv
// ----------------------------------------------------------------------------
// grs_front
// accepts items, fills the current bank and closes groups into commands
// ----------------------------------------------------------------------------
module grs_front import grs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [GS_W-1:0]   i_cfg_wdata,
    input  logic              i_push,
    input  t_grs_in           i_in,
    output logic              o_full,
    input  t_grs_rel          i_rel,
    output logic              o_wr_en,
    output logic [MEM_AW-1:0] o_wr_addr,
    output logic [DATA_W-1:0] o_wr_data,
    output logic              o_cmd_push,
    output t_grs_cmd          o_cmd
);

    logic [GS_W-1:0]      r_group_size;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [BANK_W-1:0]    r_bank, n_bank;
    logic [NUM_BANKS-1:0] r_busy, n_busy;
    logic                 accept;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     group;
    logic                 reverse;
    logic                 emit;

    // a bank still being drained by the back cannot take new items
    assign o_full     = r_busy[r_bank];
    assign accept     = i_push && !o_full;
    assign group      = grs_eff_group(r_group_size);
    assign count_next = r_fill + 1'b1;
    assign reverse    = (count_next >= group);
    assign emit       = accept && (reverse || i_in.is_final);

    assign o_wr_en    = accept;
    assign o_wr_addr  = {r_bank, r_fill[ADDR_W-1:0]};
    assign o_wr_data  = i_in.item_value;

    assign o_cmd_push    = emit;
    assign o_cmd.bank    = r_bank;
    assign o_cmd.count   = count_next;
    assign o_cmd.reverse = reverse;
    assign o_cmd.last    = i_in.is_final;

    always_comb begin
        n_fill = r_fill;
        n_bank = r_bank;
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (emit) begin
            n_busy[r_bank] = 1'b1;
            n_bank         = r_bank + 1'b1;
            n_fill         = '0;
        end else if (accept) begin
            n_fill = count_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GS_RESET;
            r_fill       <= '0;
            r_bank       <= '0;
            r_busy       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_group_size <= i_cfg_wdata;
            end
            r_fill <= n_fill;
            r_bank <= n_bank;
            r_busy <= n_busy;
        end
    end

endmodule

>>> rtl/core/grs_back.sv
// ----------------------------------------------------------------------------
// grs_back
// reads a finished group out of its bank in order or reversed
// and queues the results for the receiver
// ----------------------------------------------------------------------------
module grs_back import grs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  t_grs_cmd          i_cmd,
    output logic              o_rd_en,
    output logic [MEM_AW-1:0] o_rd_addr,
    input  logic [DATA_W-1:0] i_rd_data,
    output t_grs_rel          o_rel,
    output logic              o_empty,
    input  logic              i_pop,
    output t_grs_out          o_out
);

    logic              r_active;
    t_grs_cmd          r_cmd;
    logic [CNT_W-1:0]  r_k;
    logic              r_rd_valid;
    logic              r_rd_final;
    t_grs_out          r_q [OUT_DEPTH];
    logic [OQ_AW-1:0]  r_wp, n_wp;
    logic [OQ_AW-1:0]  r_rp, n_rp;
    logic [OQ_CW-1:0]  r_cnt, n_cnt;
    logic [OQ_CW-1:0]  occ;
    logic              issue;
    logic              last_k;
    logic [CNT_W-1:0]  idx;
    logic              pop_ok;

    // count the read in flight so the queue can never overflow
    assign occ       = r_cnt + OQ_CW'(r_rd_valid);
    assign issue     = r_active && (occ < OQ_CW'(OUT_DEPTH));
    assign last_k    = (r_k == r_cmd.count - 1'b1);
    assign idx       = r_cmd.reverse ? (r_cmd.count - 1'b1 - r_k) : r_k;
    assign o_cmd_pop = !r_active && !i_cmd_empty;
    assign o_rd_en   = issue;
    assign o_rd_addr = {r_cmd.bank, idx[ADDR_W-1:0]};
    assign o_rel.valid = issue && last_k;
    assign o_rel.bank  = r_cmd.bank;

    assign o_empty = (r_cnt == '0);
    assign o_out   = r_q[r_rp];
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_k        <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= issue;
            if (o_cmd_pop) begin
                r_active <= 1'b1;
                r_k      <= '0;
            end else if (issue) begin
                if (last_k) begin
                    r_active <= 1'b0;
                end
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (issue) begin
            r_rd_final <= r_cmd.last && last_k;
        end
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (r_rd_valid) begin
            n_wp = (r_wp == OQ_AW'(OUT_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop_ok) begin
            n_rp = (r_rp == OQ_AW'(OUT_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (r_rd_valid && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !r_rd_valid) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_q[r_wp].out_value <= i_rd_data;
            r_q[r_wp].out_final <= r_rd_final;
        end
    end

endmodule

>>> rtl/core/group_reverse_stream_top.sv
// ----------------------------------------------------------------------------
// group_reverse_stream_top
// reverses a stream of signed values in groups of a configurable size
// ----------------------------------------------------------------------------
// input side is a queue write port: an item (value plus final mark) is taken
// when i_push is high and o_full is low. results come out of a queue read
// port: o_out is valid while o_empty is low and leaves on i_pop.
// i_cfg_we / i_cfg_wdata set the group size (0 acts as 1, above 16 as 16);
// write it only while no results are pending.
// items fill one of two 16-entry banks of a ram; a full group, or the final
// item, closes the bank and the back reads it out while the front fills the
// other bank. a closed group goes through the command queue, the ram read
// register and the output queue; results then leave one per cycle while the
// output queue has room, with a pause between groups. o_full is high while
// the bank to be filled is still being drained. the back spends longer on a
// group than the front takes to fill one, so a steady stream of items sees
// o_full once per group, and for longer when the receiver stalls on i_pop.
// a 4-entry output queue sits in front of the receiver, so a stall never
// loses data. reset empties all queues and sets group size to 2; ram content
// is left as is and never read before being written.
// ----------------------------------------------------------------------------
module group_reverse_stream_top import grs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [GS_W-1:0] i_cfg_wdata,
    input  logic            i_push,
    input  t_grs_in         i_in,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output t_grs_out        o_out
);

    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              cmd_push;
    t_grs_cmd          cmd_in;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_empty;
    t_grs_cmd          cmd_out;
    t_grs_rel          rel;

    grs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .i_rel       (rel),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    grs_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (MEM_AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    grs_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    grs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd_out),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_rel       (rel),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_push && cmd_full))
        else $error("group command pushed into a full queue");

    a_bank_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_push && rel.valid) |-> (cmd_in.bank != rel.bank))
        else $error("bank closed and released in the same cycle");

    a_cmd_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |=> !cmd_empty)
        else $error("pushed group command not visible to the back");
`endif

endmodule

>>> bench/grs_checker.sv
// ----------------------------------------------------------------------------
// grs_checker
// watches the item and result queues of the group reverse stream block,
// predicts the reordered output and compares every popped result with it
// ----------------------------------------------------------------------------
module grs_checker import grs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [GS_W-1:0] i_cfg_wdata,
    input  logic            i_push,
    input  logic            i_full,
    input  t_grs_in         i_in,
    input  logic            i_empty,
    input  logic            i_pop,
    input  t_grs_out        i_out,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [DATA_W-1:0] group_store [MAX_GROUP];
    int                       held;
    logic [GS_W-1:0]          group_size;
    t_grs_out                 awaited [$];
    int                       mismatches;

    function automatic int active_group_size(input logic [GS_W-1:0] gs);
        if (gs == '0) return 1;
        if (int'(gs) > MAX_GROUP) return MAX_GROUP;
        return int'(gs);
    endfunction

    // buffer one item and queue whatever results it releases
    task automatic absorb_item(input t_grs_in it);
        int       g;
        t_grs_out r;
        g = active_group_size(group_size);
        if (held < MAX_GROUP) begin
            group_store[held] = it.item_value;
            held++;
        end
        if (held >= g) begin
            for (int k = 0; k < held; k++) begin
                r.out_value = group_store[held - 1 - k];
                r.out_final = it.is_final && (k == held - 1);
                awaited.push_back(r);
            end
            held = 0;
        end else if (it.is_final) begin
            // trailing partial group keeps its order
            for (int k = 0; k < held; k++) begin
                r.out_value = group_store[k];
                r.out_final = (k == held - 1);
                awaited.push_back(r);
            end
            held = 0;
        end
    endtask

    task automatic check_result(input t_grs_out got);
        t_grs_out want;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with nothing waiting: value %0d final %0b",
                         $realtime, got.out_value, got.out_final);
        end else begin
            want = awaited.pop_front();
            if (got.out_value !== want.out_value || got.out_final !== want.out_final) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: value exp %0d got %0d, final exp %0b got %0b",
                             $realtime, want.out_value, got.out_value,
                             want.out_final, got.out_final);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held       = 0;
            group_size = GS_RESET;
            mismatches = 0;
            awaited.delete();
        end else begin
            if (i_cfg_we) group_size = i_cfg_wdata;
            if (i_pop && !i_empty) check_result(i_out);
            if (i_push && !i_full) absorb_item(i_in);
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited.size();
    end

endmodule

>>> bench/tb_group_reverse_stream_top.sv
// ----------------------------------------------------------------------------
// tb_group_reverse_stream_top
// drives lists of signed values through the group reverse stream block under
// several group sizes, with random gaps on both sides, a long receiver stall
// that backs the block up, and checks every result through grs_checker
// ----------------------------------------------------------------------------
module tb_group_reverse_stream_top import grs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 410;

    logic            i_clk;
    logic            i_rst_n     = 1'b0;
    logic            i_cfg_we    = 1'b0;
    logic [GS_W-1:0] i_cfg_wdata = '0;
    logic            i_push      = 1'b0;
    t_grs_in         i_in        = '0;
    logic            i_pop       = 1'b0;
    logic            o_full;
    logic            o_empty;
    t_grs_out        o_out;

    int fail_count;
    int pending;
    bit steady      = 1'b0;
    int rx_hold_req = 0;
    int items_sent  = 0;

    group_reverse_stream_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

    grs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (i_push),
        .i_full       (o_full),
        .i_in         (i_in),
        .i_empty      (o_empty),
        .i_pop        (i_pop),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // receiver: random pop, or a counted hold-off when asked for one
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= steady || ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic push_item(input logic [DATA_W-1:0] value, input logic fin);
        while (!steady && $urandom_range(99) < 20) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push           <= 1'b1;
        i_in.item_value  <= value;
        i_in.is_final    <= fin;
        do @(posedge i_clk); while (o_full);
        items_sent++;
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain_all();
        i_push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_group_size(input logic [GS_W-1:0] gs);
        drain_all();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= gs;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int               n;
        logic             fin;
        logic [GS_W-1:0]  gs;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset group size of two: extremes, final item closing a full group
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h7fff_ffff, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hffff_ffff, 1'b1);
        // one-item list
        push_item(32'h0000_0005, 1'b1);

        // size zero acts as one: straight through
        write_group_size(5'd0);
        push_item(32'h1234_5678, 1'b0);

        // size above the maximum saturates to a full group of sixteen
        write_group_size(5'd31);
        for (int k = 0; k < MAX_GROUP; k++)
            push_item(32'h1000_0000 + k, k == MAX_GROUP - 1);

        // partial group at the final item keeps its order
        write_group_size(5'd5);
        push_item(32'hdead_beef, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'hfffe_0000, 1'b1);
        // group size lowered with items still buffered
        push_item(32'h0000_00aa, 1'b0);
        push_item(32'h0000_00bb, 1'b0);
        write_group_size(5'd1);
        push_item(32'h0000_00cc, 1'b0);

        // back the block up: receiver stalls while the sender keeps going
        write_group_size(5'd16);
        steady      = 1'b1;
        rx_hold_req = 400;
        for (int k = 0; k < 64; k++)
            push_item(pick_value(), k == 63);
        drain_all();
        steady = 1'b0;

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(7))
                0: gs = 5'd0;
                1: gs = 5'd1;
                2: gs = 5'd16;
                3: gs = 5'd31;
                4: gs = 5'd17;
                default: gs = GS_W'($urandom_range(2, 6));
            endcase
            write_group_size(gs);
            steady = ($urandom_range(5) == 0);
            n = $urandom_range(10, 40);
            for (int k = 0; k < n; k++) begin
                if (k == n - 1) fin = ($urandom_range(3) != 0);
                else            fin = ($urandom_range(19) == 0);
                push_item(pick_value(), fin);
            end
            steady = 1'b0;
        end
        push_item(pick_value(), 1'b1);

        drain_all();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> group_reverse_stream_top.f
rtl/core/grs_pkg.sv
rtl/core/grs_ram.sv
rtl/core/grs_cmd_fifo.sv
rtl/core/grs_front.sv
rtl/core/grs_back.sv
rtl/core/group_reverse_stream_top.sv
bench/grs_checker.sv
bench/tb_group_reverse_stream_top.sv
